// ----- design/sspq_pkg.sv -----
// shared constants and types for the stable sorted priority queue
// no dependencies
`timescale 1ns / 1ps

package sspq_pkg;

   // queue geometry
   localparam int DEPTH    = 32;
   localparam int HANDLE_W = 16;
   localparam int PRIO_W   = 32;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int ENTRY_W  = PRIO_W + HANDLE_W;

   // request operation codes
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   // controller states
   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_SEARCH  = 5'b00010,
      ST_COMPARE = 5'b00100,
      ST_SHIFT   = 5'b01000,
      ST_POP     = 5'b10000
   } state_type;

endpackage

// ----- design/sspq_ram.sv -----
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
`timescale 1ns / 1ps

module sspq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ----- design/stable_sorted_priority_queue_top.sv -----
// top level: controller for the stable sorted priority queue around one entry ram
// depends on sspq_pkg and sspq_ram
`timescale 1ns / 1ps

// A beat is taken when start is high and busy is low; each beat yields one
// result, shown for one cycle with rsp_valid high, and the receiver cannot
// stall it. Entries live in a circular buffer in one ram, so a pop is one
// ram read of the head. A push does a binary search over the held entries,
// each probe a ram read followed by a compare, then moves the entries behind
// the insert point up by one at one entry per cycle through the single write
// port, and writes the new entry into the gap. A rejected push or a pop on
// an empty queue is answered straight from idle.
// No clearing pass after reset: only held entries are ever read.
module stable_sorted_priority_queue_top
   import sspq_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_op,
   input  logic [HANDLE_W-1:0] req_message_handle,
   input  logic [PRIO_W-1:0]   req_priority_req,
   output logic                rsp_valid,
   output logic                rsp_ok,
   output logic [HANDLE_W-1:0] rsp_popped_handle,
   output logic [CNT_W-1:0]    rsp_entry_count
);

   // logical index to ram address, wrapping at DEPTH
   function automatic logic [ADDR_W-1:0] phys(input logic [ADDR_W-1:0] base,
                                              input logic [CNT_W-1:0]  idx);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(base) + (CNT_W+1)'(idx);
      if (sum >= (CNT_W+1)'(DEPTH)) begin
         sum = sum - (CNT_W+1)'(DEPTH);
      end
      return sum[ADDR_W-1:0];
   endfunction

   state_type            state_ff, state_in;
   logic [ADDR_W-1:0]    head_ff, head_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     lo_ff, lo_in;
   logic [CNT_W-1:0]     hi_ff, hi_in;
   logic [CNT_W-1:0]     mid_ff, mid_in;
   logic [CNT_W-1:0]     j_ff, j_in;
   logic                 pend_ff, pend_in;
   logic [ADDR_W-1:0]    pend_addr_ff, pend_addr_in;
   logic [PRIO_W-1:0]    prio_ff, prio_in;
   logic [HANDLE_W-1:0]  handle_ff, handle_in;

   logic                 valid_ff, valid_in;
   logic                 ok_ff, ok_in;
   logic [HANDLE_W-1:0]  popped_ff, popped_in;
   logic [CNT_W-1:0]     cnt_out_ff, cnt_out_in;

   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic [ENTRY_W-1:0]   wr_data;
   logic [ADDR_W-1:0]    rd_addr;
   logic [ENTRY_W-1:0]   rd_data;
   logic [CNT_W:0]       mid_sum;
   logic signed [PRIO_W-1:0] rd_prio;

   assign rd_prio = $signed(rd_data[ENTRY_W-1:HANDLE_W]);
   assign mid_sum = (CNT_W+1)'(lo_ff) + (CNT_W+1)'(hi_ff);

   // entry store: {priority, handle}
   sspq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // controller next state
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      j_in         = j_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      prio_in      = prio_ff;
      handle_in    = handle_ff;
      valid_in     = 1'b0;
      ok_in        = ok_ff;
      popped_in    = popped_ff;
      cnt_out_in   = cnt_out_ff;
      wr_en        = 1'b0;
      wr_addr      = pend_addr_ff;
      wr_data      = rd_data;
      rd_addr      = head_ff;

      unique case (state_ff)
         ST_IDLE: begin
            prio_in   = req_priority_req;
            handle_in = req_message_handle;
            if (start) begin
               priority if (req_op == OP_POP) begin
                  if (count_ff == '0) begin
                     valid_in   = 1'b1;
                     ok_in      = 1'b0;
                     popped_in  = '0;
                     cnt_out_in = count_ff;
                  end else begin
                     // head read issued now, data next cycle
                     state_in = ST_POP;
                  end
               end else if (req_message_handle == '0 ||
                            count_ff == CNT_W'(DEPTH)) begin
                  valid_in   = 1'b1;
                  ok_in      = 1'b0;
                  popped_in  = '0;
                  cnt_out_in = count_ff;
               end else begin
                  lo_in    = '0;
                  hi_in    = count_ff;
                  state_in = ST_SEARCH;
               end
            end
         end

         // binary search for the first entry with lower priority
         ST_SEARCH: begin
            if (lo_ff == hi_ff) begin
               j_in     = count_ff;
               pend_in  = 1'b0;
               state_in = ST_SHIFT;
            end else begin
               mid_in   = mid_sum[CNT_W:1];
               rd_addr  = phys(head_ff, mid_sum[CNT_W:1]);
               state_in = ST_COMPARE;
            end
         end

         ST_COMPARE: begin
            if (rd_prio >= $signed(prio_ff)) begin
               lo_in = mid_ff + CNT_W'(1);
            end else begin
               hi_in = mid_ff;
            end
            state_in = ST_SEARCH;
         end

         // move tail entries up by one: read each entry, then write it one slot up in the next cycle
         ST_SHIFT: begin
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = pend_addr_ff;
               wr_data = rd_data;
            end
            if (j_ff != lo_ff) begin
               rd_addr      = phys(head_ff, j_ff - CNT_W'(1));
               pend_in      = 1'b1;
               pend_addr_in = phys(head_ff, j_ff);
               j_in         = j_ff - CNT_W'(1);
            end else if (pend_ff) begin
               pend_in = 1'b0;
            end else begin
               // drop the new entry into the gap
               wr_en      = 1'b1;
               wr_addr    = phys(head_ff, lo_ff);
               wr_data    = {prio_ff, handle_ff};
               count_in   = count_ff + CNT_W'(1);
               valid_in   = 1'b1;
               ok_in      = 1'b1;
               popped_in  = '0;
               cnt_out_in = count_ff + CNT_W'(1);
               state_in   = ST_IDLE;
            end
         end

         // head data is back from the ram
         ST_POP: begin
            head_in    = phys(head_ff, CNT_W'(1));
            count_in   = count_ff - CNT_W'(1);
            valid_in   = 1'b1;
            ok_in      = 1'b1;
            popped_in  = rd_data[HANDLE_W-1:0];
            cnt_out_in = count_ff - CNT_W'(1);
            state_in   = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
         pend_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
         valid_ff <= valid_in;
      end
   end

   // working and result payload registers
   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      j_ff         <= j_in;
      pend_addr_ff <= pend_addr_in;
      prio_ff      <= prio_in;
      handle_ff    <= handle_in;
      ok_ff        <= ok_in;
      popped_ff    <= popped_in;
      cnt_out_ff   <= cnt_out_in;
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = valid_ff;
   assign rsp_ok            = ok_ff;
   assign rsp_popped_handle = popped_ff;
   assign rsp_entry_count   = cnt_out_ff;

endmodule
